// ===== hw/rtl/fetch_bucket_reorder_pipe_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fetch bucket reorder pipe
// Clocked assertion helpers with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef FETCH_BUCKET_REORDER_PIPE_CORE_ASSERT_SVH
`define FETCH_BUCKET_REORDER_PIPE_CORE_ASSERT_SVH

// Check a property while reset is released.
`define FBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fbr_pkg.sv =====
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared codes and control/status types of the fetch bucket reorder pipe.
// ----------------------------------------------------------------------------
package fbr_pkg;

    localparam logic [2:0] ACT_REQ   = 3'd0;
    localparam logic [2:0] ACT_RESP  = 3'd1;
    localparam logic [2:0] ACT_CLEAN = 3'd2;
    localparam logic [2:0] ACT_TAKE  = 3'd3;
    localparam logic [2:0] ACT_REL   = 3'd4;
    localparam logic [2:0] ACT_TICK  = 3'd5;

    localparam logic CFG_PIPE_LENGTH  = 1'b0;
    localparam logic CFG_MAX_REQUESTS = 1'b1;

    typedef struct packed {
        logic latch;     // capture the accepted request
        logic exec;      // evaluate request, response, clean, release, tick
        logic retire;    // retire one in-order entry
        logic take;      // evaluate the ready FIFO head
        logic load_out;  // move the result into the output register
    } fbr_cmd_t;

    typedef struct packed {
        logic go_retire;    // response or clean mark accepted
        logic retire_more;  // next expected entry has arrived
        logic take_loop;    // head popped without a result, look again
    } fbr_stat_t;

endpackage

// ===== hw/rtl/fbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbr_ctrl
// Sequencer of the fetch bucket reorder pipe: one request at a time.
// ----------------------------------------------------------------------------
module fbr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fbr_pkg::fbr_cmd_t cmd,
    input  fbr_pkg::fbr_stat_t stat
);
    import fbr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WAITF, ST_WAITS, ST_EXEC, ST_RETIRE, ST_TAKE, ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] act_reg, act_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    act_next  = s_tuser;
                    if (s_tuser == ACT_REQ || s_tuser == ACT_CLEAN || s_tuser == ACT_TAKE) begin
                        state_next = ST_WAITF;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_WAITF: begin
                state_next = (act_reg == ACT_TAKE) ? ST_WAITS : ST_EXEC;
            end
            ST_WAITS: begin
                state_next = ST_TAKE;
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.go_retire ? ST_RETIRE : ST_DONE;
            end
            ST_RETIRE: begin
                cmd.retire = stat.retire_more;
                state_next = stat.retire_more ? ST_RETIRE : ST_DONE;
            end
            ST_TAKE: begin
                cmd.take   = 1'b1;
                state_next = stat.take_loop ? ST_WAITF : ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_REQ;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/fbr_dpath.sv =====
// ----------------------------------------------------------------------------
// fbr_dpath
// Counters, slot store, ready FIFO and result registers of the reorder pipe.
// ----------------------------------------------------------------------------
module fbr_dpath #(
    parameter int POOL        = 64,
    parameter int CLEAN_POOL  = 64,
    parameter int SLOTS       = 128,
    parameter int FETCH_WIDTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2:0]         s_tuser,
    input  logic [23:0]        s_tdata,
    output logic [0:0]         m_tuser,
    output logic [31:0]        m_tdata,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  fbr_pkg::fbr_cmd_t  cmd,
    output fbr_pkg::fbr_stat_t stat
);
    import fbr_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int FBW = $clog2(POOL + 1);
    localparam int FCW = $clog2(CLEAN_POOL + 1);
    localparam int FW  = SW + 16;
    localparam int MW  = 40;

    logic [7:0]     pipe_reg, pipe_next;
    logic [6:0]     max_reg, max_next;
    logic [6:0]     credits_reg, credits_next;
    logic [FBW-1:0] free_b_reg, free_b_next;
    logic [FCW-1:0] free_c_reg, free_c_next;
    logic [6:0]     pend_reg, pend_next;
    logic [31:0]    time_reg, time_next;
    logic [15:0]    issue_id_reg, issue_id_next;
    logic [SW-1:0]  issue_slot_reg, issue_slot_next;
    logic [15:0]    next_id_reg, next_id_next;
    logic [SW-1:0]  next_slot_reg, next_slot_next;
    logic [SW-1:0]  head_reg, head_next;
    logic [SW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  fcount_reg, fcount_next;
    logic [CW-1:0]  arr_cnt_reg, arr_cnt_next;

    logic [2:0]  act_reg, act_next;
    logic [15:0] in_id_reg, in_id_next;
    logic [2:0]  in_cnt_reg, in_cnt_next;
    logic [3:0]  in_fm_reg, in_fm_next;

    logic        res_st_reg, res_st_next;
    logic [15:0] res_id_reg, res_id_next;
    logic [2:0]  res_drop_reg, res_drop_next;
    logic [2:0]  res_cnt_reg, res_cnt_next;
    logic [3:0]  res_fm_reg, res_fm_next;

    logic        out_st_reg, out_st_next;
    logic [26:0] out_data_reg, out_data_next;

    logic [SLOTS-1:0] arrived_reg;
    logic [SLOTS-1:0] empty_reg;
    logic [FW-1:0]    fifo_mem [SLOTS];
    logic [MW-1:0]    slot_mem [SLOTS];
    logic [FW-1:0]    fifo_rd_reg;
    logic [MW-1:0]    slot_rd_reg;

    logic [SW-1:0] h_slot;
    logic [15:0]   h_id, oldest, id_off, span;
    logic          win_full, req_ok, resp_ok, clean_ok, rel_ok;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] resp_slot;
    logic [2:0]    cnt_cl;
    logic [3:0]    fm_cl;
    logic          ret_do, push;
    logic          s_clean;
    logic [2:0]    s_cnt;
    logic [3:0]    s_fm;
    logic [31:0]   s_stamp, age;
    logic          t_empty, t_young, t_pop, recycle;
    logic [2:0]    dc, dd;
    logic [3:0]    df;
    logic          dgo;
    logic          slot_we, set_arr, set_empty, clr_req;
    logic [SW-1:0] slot_wa;
    logic [MW-1:0] slot_wd;

    function automatic logic [SW-1:0] adv_slot(input logic [15:0] id, input logic [SW-1:0] s);
        if (id == 16'hFFFF || s == SW'(SLOTS - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    assign h_slot   = fifo_rd_reg[FW-1:16];
    assign h_id     = fifo_rd_reg[15:0];
    assign oldest   = (fcount_reg != '0) ? h_id : next_id_reg;
    assign win_full = 16'(issue_id_reg - oldest) >= 16'(SLOTS);
    assign id_off   = 16'(in_id_reg - next_id_reg);
    assign span     = 16'(issue_id_reg - next_id_reg);
    assign slot_sum = {1'b0, next_slot_reg} + id_off[SW:0];
    // a wrapped id is below the window span, so it is its own slot
    assign resp_slot = (in_id_reg >= next_id_reg) ?
                       ((slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
                                                      : slot_sum[SW-1:0])
                       : in_id_reg[SW-1:0];

    assign req_ok   = (credits_reg != '0) && (free_b_reg != '0) && !win_full;
    assign resp_ok  = (id_off < span) && !arrived_reg[resp_slot];
    assign clean_ok = (free_c_reg != '0) && (pend_reg < 7'd127) && !win_full;
    assign rel_ok   = free_b_reg < FBW'(POOL);

    assign cnt_cl = ({2'b00, in_cnt_reg} > 5'(FETCH_WIDTH)) ? 3'(FETCH_WIDTH) : in_cnt_reg;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fm_cl[i] = in_fm_reg[i] && (3'(i) < cnt_cl);
        end
    end

    assign ret_do = cmd.retire && stat.retire_more;
    assign push   = ret_do && !empty_reg[next_slot_reg] && (fcount_reg < CW'(SLOTS));

    assign {s_clean, s_cnt, s_fm, s_stamp} = slot_rd_reg;
    assign age     = 32'(time_reg - s_stamp);
    assign t_empty = (fcount_reg == '0);
    assign t_young = age < {24'd0, pipe_reg};
    assign t_pop   = cmd.take && !t_empty && !t_young;

    // drop leading fakes while a clean mark is pending
    always_comb begin
        dc  = s_cnt;
        df  = s_fm;
        dd  = '0;
        dgo = (pend_reg != '0);
        for (int i = 0; i < 4; i++) begin
            if (dgo && dc != '0 && df[0]) begin
                df = {1'b0, df[3:1]};
                dc = dc - 1'b1;
                dd = dd + 1'b1;
            end else begin
                dgo = 1'b0;
            end
        end
    end
    assign recycle = (pend_reg != '0) && (dc == '0);

    assign stat.go_retire   = cmd.exec && ((act_reg == ACT_RESP && resp_ok) ||
                                           (act_reg == ACT_CLEAN && clean_ok));
    assign stat.retire_more = (next_id_reg != issue_id_reg) && arrived_reg[next_slot_reg];
    assign stat.take_loop   = !t_empty && !t_young && (s_clean || recycle);

    always_comb begin
        pipe_next       = pipe_reg;
        max_next        = max_reg;
        credits_next    = credits_reg;
        free_b_next     = free_b_reg;
        free_c_next     = free_c_reg;
        pend_next       = pend_reg;
        time_next       = time_reg;
        issue_id_next   = issue_id_reg;
        issue_slot_next = issue_slot_reg;
        next_id_next    = next_id_reg;
        next_slot_next  = next_slot_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fcount_next     = fcount_reg;
        arr_cnt_next    = arr_cnt_reg;
        act_next        = act_reg;
        in_id_next      = in_id_reg;
        in_cnt_next     = in_cnt_reg;
        in_fm_next      = in_fm_reg;
        res_st_next     = res_st_reg;
        res_id_next     = res_id_reg;
        res_drop_next   = res_drop_reg;
        res_cnt_next    = res_cnt_reg;
        res_fm_next     = res_fm_reg;
        out_st_next     = out_st_reg;
        out_data_next   = out_data_reg;
        slot_we         = 1'b0;
        slot_wa         = issue_slot_reg;
        slot_wd         = '0;
        set_arr         = 1'b0;
        set_empty       = 1'b0;
        clr_req         = 1'b0;

        if (cmd.latch) begin
            act_next      = s_tuser;
            in_id_next    = s_tdata[15:0];
            in_cnt_next   = s_tdata[18:16];
            in_fm_next    = s_tdata[22:19];
            res_st_next   = 1'b1;
            res_id_next   = '0;
            res_drop_next = '0;
            res_cnt_next  = '0;
            res_fm_next   = '0;
        end

        if (cmd.exec) begin
            case (act_reg)
                ACT_REQ: begin
                    if (req_ok) begin
                        credits_next    = credits_reg - 1'b1;
                        free_b_next     = free_b_reg - 1'b1;
                        clr_req         = 1'b1;
                        res_id_next     = issue_id_reg;
                        res_st_next     = 1'b0;
                        issue_id_next   = issue_id_reg + 1'b1;
                        issue_slot_next = adv_slot(issue_id_reg, issue_slot_reg);
                    end
                end
                ACT_RESP: begin
                    if (resp_ok) begin
                        if (credits_reg < 7'd127) credits_next = credits_reg + 1'b1;
                        arr_cnt_next = arr_cnt_reg + 1'b1;
                        slot_we      = 1'b1;
                        slot_wa      = resp_slot;
                        slot_wd      = {1'b0, cnt_cl, fm_cl, time_reg};
                        set_arr      = 1'b1;
                        set_empty    = (cnt_cl == '0);
                        res_id_next  = in_id_reg;
                        res_st_next  = 1'b0;
                    end
                end
                ACT_CLEAN: begin
                    if (clean_ok) begin
                        free_c_next     = free_c_reg - 1'b1;
                        pend_next       = pend_reg + 1'b1;
                        arr_cnt_next    = arr_cnt_reg + 1'b1;
                        slot_we         = 1'b1;
                        slot_wa         = issue_slot_reg;
                        slot_wd         = {1'b1, 3'd1, 4'd0, time_reg};
                        set_arr         = 1'b1;
                        res_id_next     = issue_id_reg;
                        res_st_next     = 1'b0;
                        issue_id_next   = issue_id_reg + 1'b1;
                        issue_slot_next = adv_slot(issue_id_reg, issue_slot_reg);
                    end
                end
                ACT_REL: begin
                    if (rel_ok) begin
                        free_b_next = free_b_reg + 1'b1;
                        res_id_next = in_id_reg;
                        res_st_next = 1'b0;
                    end
                end
                ACT_TICK: begin
                    time_next   = time_reg + 1'b1;
                    res_st_next = 1'b0;
                end
                default: ;
            endcase
        end

        if (ret_do) begin
            if (arr_cnt_reg != '0) arr_cnt_next = arr_cnt_reg - 1'b1;
            if (empty_reg[next_slot_reg]) begin
                if (free_b_reg < FBW'(POOL)) free_b_next = free_b_reg + 1'b1;
            end else if (push) begin
                tail_next   = (tail_reg == SW'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                fcount_next = fcount_reg + 1'b1;
            end
            next_id_next   = next_id_reg + 1'b1;
            next_slot_next = adv_slot(next_id_reg, next_slot_reg);
        end

        if (t_pop) begin
            head_next   = (head_reg == SW'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
            fcount_next = fcount_reg - 1'b1;
            if (s_clean) begin
                if (free_c_reg < FCW'(CLEAN_POOL)) free_c_next = free_c_reg + 1'b1;
                if (pend_reg != '0) pend_next = pend_reg - 1'b1;
            end else if (recycle) begin
                if (free_b_reg < FBW'(POOL)) free_b_next = free_b_reg + 1'b1;
            end else begin
                res_st_next   = 1'b0;
                res_id_next   = h_id;
                res_drop_next = dd;
                res_cnt_next  = dc;
                res_fm_next   = df;
            end
        end

        if (cmd.load_out) begin
            out_st_next   = res_st_reg;
            out_data_next = {(fcount_reg != '0) || (arr_cnt_reg != '0) || (credits_reg < max_reg),
                             res_fm_reg, res_cnt_reg, res_drop_reg, res_id_reg};
        end

        if (cfg_we) begin
            if (cfg_index == CFG_PIPE_LENGTH) begin
                pipe_next = cfg_wdata;
            end else begin
                max_next     = cfg_wdata[6:0];
                credits_next = cfg_wdata[6:0];
            end
        end
    end

    assign m_tuser = out_st_reg;
    assign m_tdata = {5'd0, out_data_reg};

    always_ff @(posedge aclk) begin
        fifo_rd_reg <= fifo_mem[head_reg];
        slot_rd_reg <= slot_mem[h_slot];
        if (push) begin
            fifo_mem[tail_reg] <= {next_slot_reg, next_id_reg};
        end
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arrived_reg <= '0;
        end else begin
            if (clr_req) arrived_reg[issue_slot_reg] <= 1'b0;
            if (ret_do) arrived_reg[next_slot_reg] <= 1'b0;
            if (set_arr) begin
                arrived_reg[slot_wa] <= 1'b1;
                empty_reg[slot_wa]   <= set_empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg       <= 8'd2;
            max_reg        <= 7'd4;
            credits_reg    <= 7'd4;
            free_b_reg     <= FBW'(POOL);
            free_c_reg     <= FCW'(CLEAN_POOL);
            pend_reg       <= '0;
            time_reg       <= '0;
            issue_id_reg   <= '0;
            issue_slot_reg <= '0;
            next_id_reg    <= '0;
            next_slot_reg  <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fcount_reg     <= '0;
            arr_cnt_reg    <= '0;
        end else begin
            pipe_reg       <= pipe_next;
            max_reg        <= max_next;
            credits_reg    <= credits_next;
            free_b_reg     <= free_b_next;
            free_c_reg     <= free_c_next;
            pend_reg       <= pend_next;
            time_reg       <= time_next;
            issue_id_reg   <= issue_id_next;
            issue_slot_reg <= issue_slot_next;
            next_id_reg    <= next_id_next;
            next_slot_reg  <= next_slot_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fcount_reg     <= fcount_next;
            arr_cnt_reg    <= arr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        in_id_reg    <= in_id_next;
        in_cnt_reg   <= in_cnt_next;
        in_fm_reg    <= in_fm_next;
        res_st_reg   <= res_st_next;
        res_id_reg   <= res_id_next;
        res_drop_reg <= res_drop_next;
        res_cnt_reg  <= res_cnt_next;
        res_fm_reg   <= res_fm_next;
        out_st_reg   <= out_st_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/fetch_bucket_reorder_pipe_core.sv =====
// ----------------------------------------------------------------------------
// fetch_bucket_reorder_pipe_core
// Fetch bucket manager: hands out ids, retires responses in id order and
// releases ready buckets after the pipeline delay.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         action (tuser), bucket id, count, fake mask (tdata)
//  m_*       out        status (tuser), id, drops, count, fakes, outstanding
//  cfg_*     in         pipe_length (index 0), max_requests (index 1)
//
//  Requests are handled one at a time. Release, tick and a refused response
//  go from accept to evaluate and deliver; request and clean mark add
//  a wait state first. An accepted response or clean mark then retires
//  buckets in id order. Take-next reads the ready FIFO, then the slot
//  store and evaluates, again for each head entry popped without a result.
//  Reset clears the arrived bits at once; no clearing pass is needed.
//  A stalled result sits in the output register while the next request is
//  accepted; only the following result waits for it.
// ----------------------------------------------------------------------------
`include "fetch_bucket_reorder_pipe_core_assert.svh"

module fetch_bucket_reorder_pipe_core #(
    parameter int POOL        = 64,
    parameter int CLEAN_POOL  = 64,
    parameter int SLOTS       = 128,
    parameter int FETCH_WIDTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    // [15:0] bucket_id, [18:16] instr_count, [22:19] fake_mask
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] status
    output logic [0:0]  m_tuser,
    // [15:0] out_id, [18:16] fakes_dropped, [21:19] out_count,
    // [25:22] out_fake_mask, [26] outstanding
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import fbr_pkg::*;

    fbr_cmd_t  cmd;
    fbr_stat_t stat;

    // sequence the request through fetch, evaluate, retire and deliver steps
    fbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // hold counters, slot store, ready FIFO and the output register
    fbr_dpath #(
        .POOL        (POOL),
        .CLEAN_POOL  (CLEAN_POOL),
        .SLOTS       (SLOTS),
        .FETCH_WIDTH (FETCH_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // an accepted request blocks the input until its result is loaded
    `FBR_ASSERT(a_busy, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    // never overwrite a result that is still waiting
    `FBR_ASSERT(a_no_overwrite, aclk, aresetn, cmd.load_out |-> (!m_tvalid || m_tready), "overwrite")
    // reset empties the output register
    `FBR_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

// ===== tb/tb_fetch_bucket_reorder_pipe_core.sv =====
// ----------------------------------------------------------------------------
// tb_fetch_bucket_reorder_pipe_core
// Self-checking bench for the fetch bucket manager. A scoreboard class models
// the bucket pool, in-order retirement and ready FIFO; every accepted request
// is predicted and every result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fetch_bucket_reorder_pipe_core;
    import fbr_pkg::*;

    localparam int POOL = 64;
    localparam int CLEAN_POOL = 64;
    localparam int SLOTS = 128;
    localparam int FETCH_WIDTH = 4;
    localparam int LIMIT = 5000000;

    typedef struct packed {
        logic        outstanding;
        logic [3:0]  fakes;
        logic [2:0]  count;
        logic [2:0]  dropped;
        logic [15:0] id;
        logic        status;
    } bucket_result_t;

    // Shadow model of the bucket manager plus the queue of predicted results.
    class bucket_scoreboard;
        bit [7:0]  pipe_len;
        bit [6:0]  max_req;
        bit [15:0] issue_ctr;
        bit [15:0] next_exp;
        int        credits;
        int        free_bkt;
        int        free_cln;
        int        cln_pend;
        bit [31:0] now;
        bit        s_arr[SLOTS];
        bit        s_cln[SLOTS];
        int        s_cnt[SLOTS];
        bit [3:0]  s_fk[SLOTS];
        bit [31:0] s_stamp[SLOTS];
        bit [15:0] rdy_q[$];
        int        arr_cnt;
        bucket_result_t pending_q[$];
        int        errors;
        int        mism;

        function void init();
            pipe_len = 2; max_req = 4; issue_ctr = 0; next_exp = 0;
            credits = 4; free_bkt = POOL; free_cln = CLEAN_POOL; cln_pend = 0;
            now = 0; arr_cnt = 0; rdy_q.delete();
            foreach (s_arr[i]) begin
                s_arr[i] = 0; s_cln[i] = 0; s_cnt[i] = 0; s_fk[i] = 0; s_stamp[i] = 0;
            end
        endfunction

        function void set_reg(bit idx, bit [7:0] v);
            if (idx == CFG_PIPE_LENGTH) begin
                pipe_len = v;
            end else begin
                max_req = v[6:0];
                credits = v[6:0];
            end
        endfunction

        function bit window_full();
            bit [15:0] oldest;
            bit [15:0] d;
            oldest = (rdy_q.size() != 0) ? rdy_q[0] : next_exp;
            d = issue_ctr - oldest;
            return d >= SLOTS;
        endfunction

        function void retire();
            int sl;
            for (int n = 0; n < SLOTS; n++) begin
                if (next_exp == issue_ctr) break;
                sl = next_exp % SLOTS;
                if (!s_arr[sl]) break;
                s_arr[sl] = 0;
                if (arr_cnt != 0) arr_cnt--;
                if (s_cnt[sl] == 0 && !s_cln[sl]) begin
                    if (free_bkt < POOL) free_bkt++;
                end else if (rdy_q.size() < SLOTS) begin
                    rdy_q = {rdy_q, next_exp};
                end
                next_exp++;
            end
        endfunction

        function void arrive(bit [15:0] id, bit cl, int c, bit [3:0] f);
            int sl;
            sl = id % SLOTS;
            s_arr[sl] = 1; s_cln[sl] = cl; s_cnt[sl] = c; s_fk[sl] = f;
            s_stamp[sl] = now;
            arr_cnt++;
            retire();
        endfunction

        // Note an accepted request and queue its predicted result.
        function void note_request(bit [2:0] act, bit [15:0] id, bit [2:0] cnt_in,
                                   bit [3:0] fm);
            bucket_result_t r;
            bit [15:0] id_off, span, hid;
            int c, d, sl;
            bit [3:0] f;
            r = '0;
            r.status = 1;
            case (act)
                ACT_REQ: begin
                    if (credits != 0 && free_bkt != 0 && !window_full()) begin
                        credits--; free_bkt--;
                        s_arr[issue_ctr % SLOTS] = 0;
                        r.id = issue_ctr; issue_ctr++; r.status = 0;
                    end
                end
                ACT_RESP: begin
                    id_off = id - next_exp;
                    span = issue_ctr - next_exp;
                    if (id_off < span && !s_arr[id % SLOTS]) begin
                        c = (cnt_in > FETCH_WIDTH) ? FETCH_WIDTH : cnt_in;
                        f = fm & 4'((1 << c) - 1);
                        if (credits < 127) credits++;
                        arrive(id, 0, c, f);
                        r.id = id; r.status = 0;
                    end
                end
                ACT_CLEAN: begin
                    if (free_cln != 0 && cln_pend < 127 && !window_full()) begin
                        hid = issue_ctr;
                        free_cln--; cln_pend++; issue_ctr++;
                        arrive(hid, 1, 1, 0);
                        r.id = hid; r.status = 0;
                    end
                end
                ACT_TAKE: begin
                    for (int g = 0; g <= SLOTS && rdy_q.size() != 0; g++) begin
                        hid = rdy_q[0];
                        sl = hid % SLOTS;
                        if ((now - s_stamp[sl]) < pipe_len) break;
                        void'(rdy_q.pop_front());
                        if (s_cln[sl]) begin
                            if (free_cln < CLEAN_POOL) free_cln++;
                            if (cln_pend != 0) cln_pend--;
                            continue;
                        end
                        c = s_cnt[sl]; f = s_fk[sl]; d = 0;
                        if (cln_pend != 0) begin
                            while (c != 0 && f[0]) begin
                                f = f >> 1; c--; d++;
                            end
                            if (c == 0) begin
                                if (free_bkt < POOL) free_bkt++;
                                continue;
                            end
                        end
                        r.status = 0; r.id = hid; r.dropped = 3'(d); r.count = 3'(c);
                        r.fakes = f;
                        break;
                    end
                end
                ACT_REL: begin
                    if (free_bkt < POOL) begin
                        free_bkt++; r.id = id; r.status = 0;
                    end
                end
                ACT_TICK: begin
                    now++; r.status = 0;
                end
                default: ;
            endcase
            r.outstanding = (rdy_q.size() != 0 || arr_cnt != 0 || credits < max_req);
            pending_q = {pending_q, r};
        endfunction

        // Compare one accepted result against the oldest prediction.
        function void check_result(bucket_result_t got);
            bucket_result_t exp_r;
            if (pending_q.size() == 0) begin
                errors++;
                if (mism < 10) $display("unexpected result %h", got);
                mism++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (mism < 10) begin
                    $display("mismatch: exp st=%0d id=%h drop=%0d cnt=%0d fk=%h out=%0d",
                             exp_r.status, exp_r.id, exp_r.dropped, exp_r.count,
                             exp_r.fakes, exp_r.outstanding);
                    $display("          got st=%0d id=%h drop=%0d cnt=%0d fk=%h out=%0d",
                             got.status, got.id, got.dropped, got.count,
                             got.fakes, got.outstanding);
                end
                mism++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [2:0]  s_tuser = '0;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [0:0]  m_tuser;
    logic [31:0] m_tdata;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [7:0]  cfg_wdata = '0;

    bucket_scoreboard sb;
    int  cycles = 0;
    bit  idle_on = 1;     // random idling enabled
    bit  hold_off = 0;    // long receiver stall requested
    bit [15:0] recent_ids[$];

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    fetch_bucket_reorder_pipe_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Watchdog: abort the run if it never drains.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sample results on the rising edge; remember granted ids for responses.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result({m_tdata[26:0], m_tuser[0]});
            if (!m_tuser[0]) recent_ids = {recent_ids, m_tdata[15:0]};
            if (recent_ids.size() > 64) void'(recent_ids.pop_front());
        end
    end

    // Receiver: random stall bursts, a long hold-off on request, none at the end.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    // Offer one request and hold it until the block accepts it.
    task automatic send_request(bit [2:0] act, bit [15:0] id, bit [2:0] cnt,
                                bit [3:0] fm);
        int n;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {1'b0, fm, cnt, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(act, id, cnt, fm);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    // Wait for every predicted result, then let the pipe settle.
    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(bit idx, bit [7:0] v);
        @(negedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    // Random id: mostly one that was recently granted, sometimes noise.
    function automatic bit [15:0] pick_id();
        if (recent_ids.size() != 0 && $urandom_range(0, 9) < 8)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        return 16'($urandom);
    endfunction

    task automatic random_phase(int items, int tick_bias);
        int w;
        bit [2:0] act;
        for (int i = 0; i < items; i++) begin
            w = $urandom_range(0, 99);
            if (w < 22) act = ACT_REQ;
            else if (w < 50) act = ACT_RESP;
            else if (w < 56) act = ACT_CLEAN;
            else if (w < 72) act = ACT_TAKE;
            else if (w < 76) act = ACT_REL;
            else if (w < 76 + tick_bias) act = ACT_TICK;
            else if (w < 98) act = ACT_RESP;
            else act = 3'($urandom_range(6, 7));
            send_request(act, pick_id(), 3'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.init();
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: every action, extremes, refusals and clamping.
        send_request(ACT_TAKE, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_REQ, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_REQ, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_RESP, 16'h0001, 3'd7, 4'hF);
        send_request(ACT_RESP, 16'h0001, 3'd2, 4'h3);
        send_request(ACT_RESP, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_RESP, 16'hFFFF, 3'd4, 4'h5);
        send_request(ACT_CLEAN, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_REQ, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_RESP, 16'h0003, 3'd3, 4'h1);
        send_request(ACT_TAKE, 16'h0000, 3'd0, 4'h0);
        repeat (3) send_request(ACT_TICK, 16'h0000, 3'd0, 4'h0);
        repeat (3) send_request(ACT_TAKE, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_REL, 16'hFFFF, 3'd0, 4'h0);
        send_request(ACT_REL, 16'h1234, 3'd0, 4'h0);
        send_request(3'd6, 16'hAAAA, 3'd5, 4'hA);
        send_request(3'd7, 16'h5555, 3'd6, 4'h5);
        drain();

        // Extreme settings: zero credits, short pipe.
        write_reg(CFG_MAX_REQUESTS, 8'd0);
        write_reg(CFG_PIPE_LENGTH, 8'd0);
        send_request(ACT_REQ, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_CLEAN, 16'h0000, 3'd0, 4'h0);
        send_request(ACT_TAKE, 16'h0000, 3'd0, 4'h0);
        drain();

        write_reg(CFG_MAX_REQUESTS, 8'd64);
        write_reg(CFG_PIPE_LENGTH, 8'd1);
        random_phase(350, 8);
        drain();

        // Let the result side stall for a long stretch while requests pile up.
        hold_off = 1;
        write_reg(CFG_MAX_REQUESTS, 8'd127);
        write_reg(CFG_PIPE_LENGTH, 8'd128);
        random_phase(300, 18);
        drain();

        write_reg(CFG_MAX_REQUESTS, 8'd8);
        write_reg(CFG_PIPE_LENGTH, 8'd255);
        random_phase(250, 20);
        drain();

        write_reg(CFG_MAX_REQUESTS, 8'd32);
        write_reg(CFG_PIPE_LENGTH, 8'd2);
        random_phase(350, 10);

        // Final stretch without idling.
        idle_on = 0;
        random_phase(300, 10);
        drain();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== fetch_bucket_reorder_pipe_core.f =====
+incdir+hw/rtl
hw/rtl/fbr_pkg.sv
hw/rtl/fbr_ctrl.sv
hw/rtl/fbr_dpath.sv
hw/rtl/fetch_bucket_reorder_pipe_core.sv
tb/tb_fetch_bucket_reorder_pipe_core.sv
